FILE: design/tlb_refill_with_clock_or_fifo_defines.svh
// Assertion macros for the TLB refill block.
// Depends on nothing; included by the top level, which provides clock and reset.
`ifndef TLB_REFILL_WITH_CLOCK_OR_FIFO_DEFINES_SVH
`define TLB_REFILL_WITH_CLOCK_OR_FIFO_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define TLBR_AST_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define TLBR_AST_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/tlbr_pkg.sv
// Shared constants and types for the TLB refill block.
// No dependencies; imported by tlbr_clock and the top level.
package tlbr_pkg;

   localparam int TLB_ENTRIES  = 4;
   localparam int PAGE_SIZE    = 128;
   localparam int CLOCK_ROUNDS = 2;

   localparam int IDX_W      = $clog2(TLB_ENTRIES);
   localparam int CNT_W      = $clog2(TLB_ENTRIES + 1);
   localparam int RND_W      = (CLOCK_ROUNDS > 1) ? $clog2(CLOCK_ROUNDS) : 1;
   localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);

   // Fixed field widths
   localparam int ADDR_W  = 16;
   localparam int PAGE_W  = 9;
   localparam int FRAME_W = 5;
   localparam int SLOT_W  = 2;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_BITS    = ADDR_W + 1 + FRAME_W + 3;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = 1 + FRAME_W + SLOT_W + 1 + PAGE_W + 1;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Request kinds and replacement policies
   localparam logic KIND_LOOKUP  = 1'b0;
   localparam logic KIND_REFILL  = 1'b1;
   localparam logic POLICY_FIFO  = 1'b0;
   localparam logic POLICY_CLOCK = 1'b1;

   // One word of the entry store
   typedef struct packed {
      logic               readonly;
      logic [FRAME_W-1:0] frame;
      logic [PAGE_W-1:0]  page;
   } entry_type;

   // Status of the clock victim search
   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] pick;
      logic             clr_use;
      logic [IDX_W-1:0] clr_idx;
   } clk_stat_type;

endpackage

FILE: design/tlbr_clock.sv
// Enhanced second-chance victim search, one slot per cycle.
// Depends on tlbr_pkg; the use/dirty bits it reads live in the top level.
module tlbr_clock (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [tlbr_pkg::IDX_W-1:0]                hand_start,
   input  logic [tlbr_pkg::TLB_ENTRIES-1:0]          use_bits,
   input  logic [tlbr_pkg::TLB_ENTRIES-1:0]          dirty_bits,
   output tlbr_pkg::clk_stat_type                    stat
);
   import tlbr_pkg::*;

   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] h_ff, h_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             passb_ff, passb_in;
   logic [RND_W-1:0] round_ff, round_in;
   logic [IDX_W-1:0] h_next;
   logic             match;

   // Wrap the hand at the last slot
   assign h_next = (h_ff == IDX_W'(TLB_ENTRIES - 1)) ? '0 : h_ff + 1'b1;

   // First pass wants use=0/dirty=0, second pass use=0/dirty=1
   assign match = !use_bits[h_ff] && (dirty_bits[h_ff] == passb_ff);

   // Step the hand one slot per cycle
   always_comb begin
      busy_in      = busy_ff;
      h_in         = h_ff;
      cnt_in       = cnt_ff;
      passb_in     = passb_ff;
      round_in     = round_ff;
      stat.done    = 1'b0;
      stat.pick    = h_ff;
      stat.clr_use = 1'b0;
      stat.clr_idx = h_ff;
      if (start) begin
         busy_in  = 1'b1;
         h_in     = hand_start;
         cnt_in   = '0;
         passb_in = 1'b0;
         round_in = '0;
      end else if (busy_ff) begin
         if (match) begin
            stat.done = 1'b1;
            busy_in   = 1'b0;
         end else begin
            stat.clr_use = passb_ff;
            h_in         = h_next;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(TLB_ENTRIES - 1)) begin
               cnt_in = '0;
               if (!passb_ff) begin
                  passb_in = 1'b1;
               end else if (round_ff == RND_W'(CLOCK_ROUNDS - 1)) begin
                  // No victim after all rounds: take the slot under the hand
                  stat.done = 1'b1;
                  stat.pick = h_next;
                  busy_in   = 1'b0;
               end else begin
                  passb_in = 1'b0;
                  round_in = round_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      h_ff     <= h_in;
      cnt_ff   <= cnt_in;
      passb_ff <= passb_in;
      round_ff <= round_in;
   end

endmodule

FILE: design/tlb_refill_with_clock_or_fifo.sv
// Fully associative TLB with lookup and refill, FIFO or enhanced clock eviction.
// A lookup sweeps the slots in order and stops at the first hit; a refill writes the lowest
// free slot directly, FIFO eviction first shifts every slot down one place, and clock eviction
// first runs the victim search. The sequencer takes one item at a time, paced by the store
// sweep and the clock search; it takes the next beat once its result is in the output register.
// Reset (synchronous) clears valid, use and dirty bits, the hand, and sets clock policy.
module tlb_refill_with_clock_or_fifo (
   input  logic                                 clock,
   input  logic                                 reset,
   // csr_data: policy
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_data,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // req_tdata: virtual_address, is_write, entry_frame, entry_use, entry_dirty,
   // entry_readonly, zero pad
   input  logic [tlbr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // req_tuser: kind
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // rsp_tdata: hit, frame, slot, evicted, evicted_page, evicted_dirty, zero pad
   output logic [tlbr_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import tlbr_pkg::*;

   `include "tlb_refill_with_clock_or_fifo_defines.svh"

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOOK  = 3'd1;
   localparam logic [2:0] ST_CLOCK = 3'd2;
   localparam logic [2:0] ST_EVRD  = 3'd3;
   localparam logic [2:0] ST_EVCAP = 3'd4;
   localparam logic [2:0] ST_SHIFT = 3'd5;
   localparam logic [2:0] ST_FILL  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic                   policy_ff, policy_in;
   logic [TLB_ENTRIES-1:0] valid_ff, valid_in;
   logic [TLB_ENTRIES-1:0] use_ff, use_in;
   logic [TLB_ENTRIES-1:0] dirty_ff, dirty_in;
   logic [IDX_W-1:0]       hand_ff, hand_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]       target_ff, target_in;

   // Captured request
   logic [PAGE_W-1:0]      page_ff, page_in;
   logic                   is_write_ff, is_write_in;
   logic [FRAME_W-1:0]     new_frame_ff, new_frame_in;
   logic                   new_use_ff, new_use_in;
   logic                   new_dirty_ff, new_dirty_in;
   logic                   new_ro_ff, new_ro_in;

   // Staged result
   logic                   res_hit_ff, res_hit_in;
   logic [FRAME_W-1:0]     res_frame_ff, res_frame_in;
   logic [IDX_W-1:0]       res_slot_ff, res_slot_in;
   logic                   res_ev_ff, res_ev_in;
   logic [PAGE_W-1:0]      res_evp_ff, res_evp_in;
   logic                   res_evd_ff, res_evd_in;

   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // Entry store: page, frame and read-only bit per slot
   entry_type              store_mem [TLB_ENTRIES];
   entry_type              rdata_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_wa;
   entry_type              mem_wd;

   logic                   free_any;
   logic [IDX_W-1:0]       free_idx;
   logic [IDX_W-1:0]       cmp_idx;
   logic                   clk_start;
   clk_stat_type           clk_stat;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign cmp_idx    = IDX_W'(cnt_ff - 1'b1);

   // Find the lowest invalid slot
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   tlbr_clock u_clock (
      .clock      (clock),
      .reset      (reset),
      .start      (clk_start),
      .hand_start (hand_ff),
      .use_bits   (use_ff),
      .dirty_bits (dirty_ff),
      .stat       (clk_stat)
   );

   // Sequencer: sweep the store, modify, write back
   always_comb begin
      state_in      = state_ff;
      policy_in     = policy_ff;
      valid_in      = valid_ff;
      use_in        = use_ff;
      dirty_in      = dirty_ff;
      hand_in       = hand_ff;
      cnt_in        = cnt_ff;
      target_in     = target_ff;
      page_in       = page_ff;
      is_write_in   = is_write_ff;
      new_frame_in  = new_frame_ff;
      new_use_in    = new_use_ff;
      new_dirty_in  = new_dirty_ff;
      new_ro_in     = new_ro_ff;
      res_hit_in    = res_hit_ff;
      res_frame_in  = res_frame_ff;
      res_slot_in   = res_slot_ff;
      res_ev_in     = res_ev_ff;
      res_evp_in    = res_evp_ff;
      res_evd_in    = res_evd_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rd_addr       = '0;
      mem_we        = 1'b0;
      mem_wa        = target_ff;
      mem_wd        = rdata_ff;
      clk_start     = 1'b0;

      if (csr_valid) begin
         policy_in = csr_data;
      end

      // Clear use bits the clock hand passes over in the dirty sweep
      if (clk_stat.clr_use) begin
         use_in[clk_stat.clr_idx] = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               page_in      = PAGE_W'(req_tdata[ADDR_W-1:0] >> PAGE_SHIFT);
               is_write_in  = req_tdata[ADDR_W];
               new_frame_in = req_tdata[ADDR_W+FRAME_W:ADDR_W+1];
               new_use_in   = req_tdata[ADDR_W+FRAME_W+1];
               new_dirty_in = req_tdata[ADDR_W+FRAME_W+2];
               new_ro_in    = req_tdata[ADDR_W+FRAME_W+3];
               cnt_in       = '0;
               res_hit_in   = 1'b0;
               res_frame_in = '0;
               res_slot_in  = '0;
               res_ev_in    = 1'b0;
               res_evp_in   = '0;
               res_evd_in   = 1'b0;
               if (req_tuser == KIND_LOOKUP) begin
                  state_in = ST_LOOK;
               end else if (free_any) begin
                  target_in = free_idx;
                  state_in  = ST_FILL;
               end else if (policy_ff == POLICY_FIFO) begin
                  res_ev_in  = 1'b1;
                  res_evd_in = dirty_ff[0];
                  target_in  = IDX_W'(TLB_ENTRIES - 1);
                  state_in   = ST_SHIFT;
               end else begin
                  res_ev_in = 1'b1;
                  clk_start = 1'b1;
                  state_in  = ST_CLOCK;
               end
            end
         end
         ST_LOOK: begin
            // Read slot cnt, compare the slot read last cycle
            rd_addr = cnt_ff[IDX_W-1:0];
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               if (valid_ff[cmp_idx] && rdata_ff.page == page_ff) begin
                  res_hit_in       = 1'b1;
                  res_frame_in     = rdata_ff.frame;
                  res_slot_in      = cmp_idx;
                  use_in[cmp_idx]  = 1'b1;
                  if (is_write_ff) begin
                     dirty_in[cmp_idx] = 1'b1;
                  end
                  state_in = ST_DONE;
               end else if (cnt_ff == CNT_W'(TLB_ENTRIES)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CLOCK: begin
            if (clk_stat.done) begin
               target_in  = clk_stat.pick;
               hand_in    = clk_stat.pick;
               res_evd_in = dirty_ff[clk_stat.pick];
               state_in   = ST_EVRD;
            end
         end
         ST_EVRD: begin
            rd_addr  = target_ff;
            state_in = ST_EVCAP;
         end
         ST_EVCAP: begin
            res_evp_in = rdata_ff.page;
            state_in   = ST_FILL;
         end
         ST_SHIFT: begin
            // Read slot cnt, write the slot read last cycle one place down
            rd_addr = cnt_ff[IDX_W-1:0];
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               res_evp_in = rdata_ff.page;
            end
            if (cnt_ff >= CNT_W'(2)) begin
               mem_we = 1'b1;
               mem_wa = IDX_W'(cnt_ff - CNT_W'(2));
               mem_wd = rdata_ff;
            end
            if (cnt_ff == CNT_W'(TLB_ENTRIES)) begin
               for (int i = 0; i < TLB_ENTRIES - 1; i++) begin
                  use_in[i]   = use_ff[i+1];
                  dirty_in[i] = dirty_ff[i+1];
               end
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            mem_we              = 1'b1;
            mem_wa              = target_ff;
            mem_wd.readonly     = new_ro_ff;
            mem_wd.frame        = new_frame_ff;
            mem_wd.page         = page_ff;
            valid_in[target_ff] = 1'b1;
            use_in[target_ff]   = new_use_ff;
            dirty_in[target_ff] = new_dirty_ff;
            res_frame_in        = new_frame_ff;
            res_slot_in         = target_ff;
            state_in            = ST_DONE;
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_TDATA_W'({res_evd_ff, res_evp_ff, res_ev_ff,
                                             SLOT_W'(res_slot_ff), res_frame_ff,
                                             res_hit_ff});
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Entry store with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         policy_ff     <= POLICY_CLOCK;
         valid_ff      <= '0;
         use_ff        <= '0;
         dirty_ff      <= '0;
         hand_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         policy_ff     <= policy_in;
         valid_ff      <= valid_in;
         use_ff        <= use_in;
         dirty_ff      <= dirty_in;
         hand_ff       <= hand_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      cnt_ff       <= cnt_in;
      target_ff    <= target_in;
      page_ff      <= page_in;
      is_write_ff  <= is_write_in;
      new_frame_ff <= new_frame_in;
      new_use_ff   <= new_use_in;
      new_dirty_ff <= new_dirty_in;
      new_ro_ff    <= new_ro_in;
      res_hit_ff   <= res_hit_in;
      res_frame_ff <= res_frame_in;
      res_slot_ff  <= res_slot_in;
      res_ev_ff    <= res_ev_in;
      res_evp_ff   <= res_evp_in;
      res_evd_ff   <= res_evd_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // Eviction only runs on a full TLB
   `TLBR_AST_NOW(a_evict_when_full, (state_ff == ST_CLOCK || state_ff == ST_SHIFT), (&valid_ff), "eviction with a free slot")
   // A fill leaves its slot valid
   `TLBR_AST_NXT(a_fill_valid, (state_ff == ST_FILL), (valid_ff[target_ff]), "filled slot not valid")
   // A new result appears only out of the done state
   `TLBR_AST_NOW(a_rsp_from_done, ($rose(rsp_tvalid_ff)), ($past(state_ff) == ST_DONE), "result outside done state")

endmodule

FILE: bench/tlb_refill_with_clock_or_fifo_test.sv
// Self-checking bench for the fully associative TLB with FIFO or enhanced clock refill.
// Depends on tlbr_pkg and tlb_refill_with_clock_or_fifo; drives stream beats, predicts
// each response with a local TLB model and checks it against the response stream.
`timescale 1ns / 1ps

module tlb_refill_with_clock_or_fifo_test;
   import tlbr_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 210;
   localparam int POOL_PAGES = 8;
   localparam int MAX_REPORTS = 10;

   // Request fields, lowest bit first from the bottom of the struct
   typedef struct packed {
      logic               readonly;
      logic               dirty;
      logic               use_bit;
      logic [FRAME_W-1:0] frame;
      logic               is_write;
      logic [ADDR_W-1:0]  vaddr;
   } req_fields_type;

   // Response fields, hit in bit 0
   typedef struct packed {
      logic               ev_dirty;
      logic [PAGE_W-1:0]  ev_page;
      logic               evicted;
      logic [SLOT_W-1:0]  slot;
      logic [FRAME_W-1:0] frame;
      logic               hit;
   } rsp_fields_type;

   typedef enum logic {ROW_BEAT, ROW_POLICY} row_op_type;

   typedef struct {
      row_op_type     op;
      logic           kind;
      req_fields_type req;
      bit             typed;
      rsp_fields_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_data = 1'b0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   tlb_refill_with_clock_or_fifo u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow TLB state
   logic               shadow_policy;
   bit                 shadow_valid [TLB_ENTRIES];
   logic [PAGE_W-1:0]  shadow_page [TLB_ENTRIES];
   logic [FRAME_W-1:0] shadow_frame [TLB_ENTRIES];
   bit                 shadow_use [TLB_ENTRIES];
   bit                 shadow_dirty [TLB_ENTRIES];
   bit                 shadow_ro [TLB_ENTRIES];
   int                 shadow_hand;

   rsp_fields_type awaited_rsp [$];
   rsp_fields_type last_rsp;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int err_count = 0;
   int cycle_count = 0;
   int n_hit = 0, n_miss = 0, n_fill = 0, n_fifo_ev = 0, n_clock_ev = 0;

   // Enhanced second chance: two rounds of a clean sweep then a dirty sweep
   function automatic int clock_victim();
      int h;
      h = shadow_hand;
      for (int r = 0; r < CLOCK_ROUNDS; r++) begin
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (!shadow_use[h] && !shadow_dirty[h]) begin
               shadow_hand = h;
               return h;
            end
            h = (h + 1) % TLB_ENTRIES;
         end
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (!shadow_use[h] && shadow_dirty[h]) begin
               shadow_hand = h;
               return h;
            end
            shadow_use[h] = 0;
            h = (h + 1) % TLB_ENTRIES;
         end
      end
      shadow_hand = h;
      return h;
   endfunction

   // Apply one lookup or refill to the shadow TLB and return its response
   function automatic rsp_fields_type translate_or_refill(logic kind, req_fields_type r);
      rsp_fields_type o;
      logic [PAGE_W-1:0] pg;
      int tgt;
      bit found;
      o = '0;
      pg = PAGE_W'(r.vaddr / PAGE_SIZE);
      if (kind == KIND_LOOKUP) begin
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (shadow_valid[i] && shadow_page[i] == pg) begin
               shadow_use[i] = 1;
               if (r.is_write) shadow_dirty[i] = 1;
               o.hit = 1'b1;
               o.frame = shadow_frame[i];
               o.slot = SLOT_W'(i);
               break;
            end
         end
      end else begin
         tgt = 0;
         found = 0;
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (!shadow_valid[i]) begin
               tgt = i;
               found = 1;
               break;
            end
         end
         if (!found) begin
            o.evicted = 1'b1;
            if (shadow_policy == POLICY_FIFO) begin
               o.ev_page = shadow_page[0];
               o.ev_dirty = shadow_dirty[0];
               // shift every slot down by one
               for (int i = 0; i + 1 < TLB_ENTRIES; i++) begin
                  shadow_valid[i] = shadow_valid[i+1];
                  shadow_page[i] = shadow_page[i+1];
                  shadow_frame[i] = shadow_frame[i+1];
                  shadow_use[i] = shadow_use[i+1];
                  shadow_dirty[i] = shadow_dirty[i+1];
                  shadow_ro[i] = shadow_ro[i+1];
               end
               tgt = TLB_ENTRIES - 1;
            end else begin
               tgt = clock_victim();
               o.ev_page = shadow_page[tgt];
               o.ev_dirty = shadow_dirty[tgt];
            end
         end
         shadow_valid[tgt] = 1;
         shadow_page[tgt] = pg;
         shadow_frame[tgt] = r.frame;
         shadow_use[tgt] = r.use_bit;
         shadow_dirty[tgt] = r.dirty;
         shadow_ro[tgt] = r.readonly;
         o.frame = r.frame;
         o.slot = SLOT_W'(tgt);
      end
      return o;
   endfunction

   // Present one request beat, hold it until accepted, then book its response
   task automatic send_beat(input logic kind, input req_fields_type r, input bit typed,
                            input rsp_fields_type typed_rsp);
      logic [REQ_TDATA_W-1:0] word;
      rsp_fields_type pred;
      word = '0;
      word[REQ_BITS-1:0] = r;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= word;
      do @(posedge clock); while (!req_tready);
      pred = translate_or_refill(kind, r);
      if (typed) pred = typed_rsp;
      awaited_rsp.push_back(pred);
      last_rsp = pred;
      if (kind == KIND_LOOKUP) begin
         if (pred.hit) n_hit++;
         else n_miss++;
      end else if (!pred.evicted) n_fill++;
      else if (shadow_policy == POLICY_FIFO) n_fifo_ev++;
      else n_clock_ev++;
   endtask

   // Drop valid and hold until every booked response has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_rsp.size() != 0);
   endtask

   // Write the policy register while the TLB is idle
   task automatic write_policy(input logic value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_policy = value;
   endtask

   // Random traffic: mostly pool pages, a miss usually followed by its refill
   task automatic run_random(input int count);
      logic [PAGE_W-1:0] pool [POOL_PAGES];
      bit refill_due;
      logic [ADDR_W-1:0] miss_addr;
      logic kind;
      req_fields_type r;
      refill_due = 0;
      miss_addr = '0;
      for (int i = 0; i < POOL_PAGES; i++) pool[i] = PAGE_W'($urandom_range(0, 511));
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) drain_results();
         r = req_fields_type'(REQ_BITS'($urandom));
         if (refill_due && $urandom_range(0, 99) < 85) begin
            kind = KIND_REFILL;
            r.vaddr = miss_addr;
         end else begin
            kind = ($urandom_range(0, 99) < 20) ? KIND_REFILL : KIND_LOOKUP;
            if ($urandom_range(0, 99) < 75)
               r.vaddr = {pool[$urandom_range(0, POOL_PAGES - 1)], 7'($urandom_range(0, 127))};
         end
         refill_due = 0;
         send_beat(kind, r, 0, '0);
         if (kind == KIND_LOOKUP && !last_rsp.hit) begin
            refill_due = 1;
            miss_addr = r.vaddr;
         end
      end
   endtask

   // Response stall pattern
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  awaited_rsp.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Compare each response beat with the oldest booked one
   always @(posedge clock) begin : check_rsp
      rsp_fields_type got, want;
      bit bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_BITS-1:0];
         if (awaited_rsp.size() == 0) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
               $display("unexpected response beat %h at cycle %0d", got, cycle_count);
         end else begin
            want = awaited_rsp.pop_front();
            bad = (got.hit !== want.hit) || (got.frame !== want.frame) ||
                  (got.slot !== want.slot) || (got.evicted !== want.evicted) ||
                  (got.ev_page !== want.ev_page) || (got.ev_dirty !== want.ev_dirty);
            if (bad) begin
               err_count++;
               if (err_count <= MAX_REPORTS) begin
                  $write("cycle %0d: hit %b/%b frame %0d/%0d slot %0d/%0d ",
                         cycle_count, want.hit, got.hit, want.frame, got.frame,
                         want.slot, got.slot);
                  $display("evicted %b/%b page %0d/%0d dirty %b/%b (expected/actual)",
                           want.evicted, got.evicted, want.ev_page, got.ev_page,
                           want.ev_dirty, got.ev_dirty);
               end
            end
         end
      end
   end

   stim_row_type directed_rows [$];

   function automatic void add_row(logic kind, logic [15:0] addr, logic wr,
                                   logic [4:0] fr, logic u, logic d, logic ro,
                                   bit typed, logic hit, logic [4:0] fr_o, logic [1:0] slot);
      stim_row_type row;
      row.op = ROW_BEAT;
      row.kind = kind;
      row.req = '{readonly: ro, dirty: d, use_bit: u, frame: fr, is_write: wr, vaddr: addr};
      row.typed = typed;
      row.want = '0;
      row.want.hit = hit;
      row.want.frame = fr_o;
      row.want.slot = slot;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_policy(logic value);
      stim_row_type row;
      row = '{op: ROW_POLICY, kind: KIND_LOOKUP, req: '0, typed: 0, want: '0};
      row.req.readonly = value;
      directed_rows.push_back(row);
   endfunction

   initial begin
      shadow_policy = POLICY_CLOCK;
      shadow_hand = 0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         shadow_valid[i] = 0;
         shadow_page[i] = '0;
         shadow_frame[i] = '0;
         shadow_use[i] = 0;
         shadow_dirty[i] = 0;
         shadow_ro[i] = 0;
      end

      // misses on an empty TLB, fill all four free slots, hit extremes
      add_row(KIND_LOOKUP, 16'h0000, 0, 5'd0, 0, 0, 0, 1, 0, 5'd0, 2'd0);
      add_row(KIND_LOOKUP, 16'hFFFF, 1, 5'd31, 1, 1, 1, 1, 0, 5'd0, 2'd0);
      add_row(KIND_REFILL, 16'h0000, 0, 5'd0, 0, 0, 0, 1, 0, 5'd0, 2'd0);
      add_row(KIND_REFILL, 16'hFFFF, 1, 5'd31, 1, 1, 1, 1, 0, 5'd31, 2'd1);
      add_row(KIND_REFILL, 16'h0080, 0, 5'd10, 0, 1, 0, 1, 0, 5'd10, 2'd2);
      add_row(KIND_REFILL, 16'h0100, 0, 5'd21, 1, 0, 1, 1, 0, 5'd21, 2'd3);
      // write hit on a read-only slot still sets dirty
      add_row(KIND_LOOKUP, 16'hFFFF, 1, 5'd0, 0, 0, 0, 1, 1, 5'd31, 2'd1);
      add_row(KIND_LOOKUP, 16'h007F, 0, 5'd0, 0, 0, 0, 1, 1, 5'd0, 2'd0);
      // clock eviction through the dirty sweep, duplicate page install
      add_row(KIND_REFILL, 16'h0000, 0, 5'd3, 0, 0, 0, 0, 0, 5'd0, 2'd0);
      add_row(KIND_LOOKUP, 16'h0000, 1, 5'd0, 0, 0, 0, 0, 0, 5'd0, 2'd0);
      add_row(KIND_REFILL, 16'h0200, 0, 5'd7, 1, 1, 0, 0, 0, 5'd0, 2'd0);
      add_row(KIND_LOOKUP, 16'h0181, 1, 5'd0, 0, 0, 0, 0, 0, 5'd0, 2'd0);
      // FIFO shift evictions
      add_policy(POLICY_FIFO);
      add_row(KIND_REFILL, 16'h1234, 0, 5'd17, 0, 1, 1, 0, 0, 5'd0, 2'd0);
      add_row(KIND_REFILL, 16'hFF80, 1, 5'd31, 1, 0, 0, 0, 0, 5'd0, 2'd0);
      add_row(KIND_LOOKUP, 16'hFF80, 0, 5'd0, 0, 0, 0, 0, 0, 5'd0, 2'd0);
      add_policy(POLICY_CLOCK);
      add_row(KIND_REFILL, 16'h8000, 0, 5'd12, 0, 0, 0, 0, 0, 5'd0, 2'd0);
      add_row(KIND_LOOKUP, 16'h8000, 1, 5'd0, 0, 0, 0, 0, 0, 5'd0, 2'd0);
      add_row(KIND_LOOKUP, 16'h4000, 0, 5'd0, 0, 0, 0, 0, 0, 5'd0, 2'd0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == ROW_POLICY) write_policy(directed_rows[i].req.readonly);
         else send_beat(directed_rows[i].kind, directed_rows[i].req, directed_rows[i].typed,
                        directed_rows[i].want);
      end

      // idle and stall phases, each run under both policies
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 64; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 64; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         write_policy(POLICY_FIFO);
         run_random(RANDOM_ITEMS);
         write_policy(POLICY_CLOCK);
         run_random(RANDOM_ITEMS);
      end

      drain_results();
      repeat (40) @(posedge clock);

      $display("lookups: %0d hits, %0d misses; refills: %0d into free slots,",
               n_hit, n_miss, n_fill);
      $display("%0d FIFO evictions, %0d clock evictions; %0d errors",
               n_fifo_ev, n_clock_ev, err_count);
      if (err_count == 0 && awaited_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
